[rtl/core/gmdfs_pkg.sv]
// Shared types and constants for the graph adjacency-matrix search engine.
// Depends on nothing; every file of the block imports it.
`default_nettype none

package gmdfs_pkg;

	// Fixed field widths of the request and result channels.
	localparam int MODE_W  = 2;
	localparam int VID_W   = 5;
	localparam int VC_W    = 6;
	localparam int COUNT_W = 9;

	// Request operation codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	// Result status codes.
	localparam logic STATUS_OK         = 1'b0;
	localparam logic STATUS_BAD_VERTEX = 1'b1;

	// Vertex count after reset.
	localparam logic [VC_W-1:0] VC_RESET = 6'd32;

endpackage

`default_nettype wire

[rtl/core/graph_matrix_dfs_engine_top.sv]
// Top level of the graph adjacency-matrix engine with depth-first search.
// Depends on gmdfs_pkg for field widths, operation codes and status codes.
`default_nettype none

// The block stores an undirected graph as a symmetric adjacency bit matrix
// and keeps a count of its edges. A request either inserts an edge, removes
// an edge, or runs a depth-first search from vertex_a. Insert and remove
// answer with one result that carries the status and the new edge count.
// A search answers with one result per visited vertex, in visiting order,
// with last set on the final one; unvisited neighbors are taken in
// ascending order. The block takes one request at a time: req_stall is
// high from the accepted request until its final result has been loaded
// into the output register, which can still be waiting on res_stall while
// the next request is accepted. An edge update that changes the graph goes
// through row read, row write with mirror read, mirror write and result.
// One that leaves the graph unchanged skips the mirror write, and a request
// with an invalid vertex or the unused operation goes straight to the
// result. A search spends one scan step on each vertex it visits, and a
// backtrack out of a vertex takes a scan step and then a pop step. This
// pace is set by the single read port of the adjacency row memory and of
// the walk stack: each step reads one row, and a backtrack first reads the
// stack and then the row of the uncovered vertex. The next candidate vertex
// comes from one shared find-first unit that isolates the lowest set bit of
// the unvisited neighbor mask with one wide add. The vertex count register
// is written through the cfg channel, which is always ready; it should only
// be written while no request is in flight. The adjacency rows come out of
// reset as empty through one valid bit per row, so no clearing pass is
// needed.

module graph_matrix_dfs_engine_top
	import gmdfs_pkg::*;
#(
	parameter int MAX_VERTICES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [VC_W-1:0]     vertex_count,

	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [VID_W-1:0]    vertex_a,
	input  wire logic [VID_W-1:0]    vertex_b,

	output logic                     res_valid,
	input  wire logic                res_stall,
	output logic [VID_W-1:0]         visited_vertex,
	output logic                     status,
	output logic [COUNT_W-1:0]       edge_count,
	output logic                     last
);

	// Vertex index width, stack depth width, and the width used to compare
	// vertex ids against the active vertex count.
	localparam int VI_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
	localparam int N_W     = (DEPTH_W > VC_W) ? DEPTH_W : VC_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EUPD,
		S_EWR_B,
		S_RESP,
		S_SCAN,
		S_POP
	} state_t;

	state_t                   state_q;
	mode_t                    mode_q;
	logic [VC_W-1:0]          vc_q;
	logic [COUNT_W-1:0]       edges_q;
	logic [MAX_VERTICES-1:0]  visited_q;
	logic [DEPTH_W-1:0]       depth_q;
	logic [VI_W-1:0]          a_q;
	logic [VI_W-1:0]          b_q;
	logic [VI_W-1:0]          top_q;
	logic [VI_W-1:0]          pend_q;
	logic                     resp_status_q;

	logic                     res_valid_q;
	logic [VID_W-1:0]         res_vertex_q;
	logic                     res_status_q;
	logic [COUNT_W-1:0]       res_count_q;
	logic                     res_last_q;

	// Adjacency row memory with one valid bit per row; a row never written
	// since reset reads as empty.
	logic [MAX_VERTICES-1:0]  adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]  row_vld_q;
	logic [MAX_VERTICES-1:0]  rd_q;
	logic                     rd_vld_q;
	logic                     mem_we;
	logic [VI_W-1:0]          mem_waddr;
	logic [MAX_VERTICES-1:0]  mem_wdata;
	logic [VI_W-1:0]          mem_raddr;

	// Walk stack memory; entries are always written before they are read.
	logic [VI_W-1:0]          stk_mem [MAX_VERTICES];
	logic [VI_W-1:0]          stk_rd_q;
	logic                     stk_we;
	logic [VI_W-1:0]          stk_waddr;
	logic [VI_W-1:0]          stk_wdata;
	logic [VI_W-1:0]          stk_raddr;
	logic [DEPTH_W-1:0]       depth_m2;

	logic [N_W-1:0]           max_n;
	logic [N_W-1:0]           vc_n;
	logic [N_W-1:0]           act_n;
	logic [MAX_VERTICES-1:0]  allowed;
	logic                     a_in_ok;
	logic                     b_in_ok;
	logic [VI_W-1:0]          a_in;
	logic [MAX_VERTICES-1:0]  a_in_bit;

	logic [MAX_VERTICES-1:0]  row_eff;
	logic [MAX_VERTICES-1:0]  cand;
	logic [MAX_VERTICES-1:0]  iso;
	logic                     cand_nz;
	logic [VI_W-1:0]          ffs_idx;
	logic                     out_free;
	logic                     res_load;
	logic                     has_edge;
	logic                     do_change;

	assign cfg_ready      = 1'b1;
	assign req_stall      = (state_q != S_IDLE);
	assign res_valid      = res_valid_q;
	assign visited_vertex = res_vertex_q;
	assign status         = res_status_q;
	assign edge_count     = res_count_q;
	assign last           = res_last_q;

	// Active vertex count is the register clipped to the row count.
	always_comb begin
		max_n = N_W'(MAX_VERTICES);
		vc_n  = N_W'(vc_q);
		act_n = (vc_n > max_n) ? max_n : vc_n;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			allowed[i] = (N_W'(i) < act_n);
		end
		a_in_ok  = (N_W'(vertex_a) < act_n);
		b_in_ok  = (N_W'(vertex_b) < act_n);
		a_in     = VI_W'(vertex_a);
		a_in_bit = MAX_VERTICES'(1) << a_in;
	end

	// Shared find-first unit: isolate the lowest unvisited neighbor, then
	// encode its position.
	always_comb begin
		row_eff = rd_vld_q ? rd_q : '0;
		cand    = row_eff & ~visited_q & allowed;
		iso     = cand & (~cand + MAX_VERTICES'(1));
		cand_nz = |cand;
		ffs_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (iso[i]) begin
				ffs_idx = ffs_idx | VI_W'(i);
			end
		end
		out_free = !res_valid_q || !res_stall;
		// The output register takes a new result, once it is free, in the response
		// step and in every scan step that either finds a neighbor or ends the walk.
		res_load = out_free && ((state_q == S_RESP) ||
			(state_q == S_SCAN && (cand_nz || depth_q == DEPTH_W'(1))));
		has_edge = row_eff[b_q];
		if (mode_q == MODE_INSERT) begin
			do_change = (a_q != b_q) && !has_edge;
		end else begin
			do_change = has_edge;
		end
		depth_m2 = depth_q - DEPTH_W'(2);
	end

	// Row memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = a_q;
		mem_wdata = row_eff ^ (MAX_VERTICES'(1) << b_q);
		if (state_q == S_EUPD && do_change) begin
			mem_we = 1'b1;
		end else if (state_q == S_EWR_B) begin
			mem_we    = 1'b1;
			mem_waddr = b_q;
			mem_wdata = row_eff ^ (MAX_VERTICES'(1) << a_q);
		end
		unique case (state_q)
			S_IDLE:  mem_raddr = a_in;
			S_EUPD:  mem_raddr = b_q;
			S_SCAN:  mem_raddr = (cand_nz && out_free) ? ffs_idx : top_q;
			S_POP:   mem_raddr = stk_rd_q;
			default: mem_raddr = top_q;
		endcase
	end

	// Stack port control: the start vertex is pushed on accept, each newly
	// visited vertex is pushed in the scan step.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = a_in;
		if (state_q == S_IDLE && req_valid && mode_t'(mode) == MODE_SEARCH && a_in_ok) begin
			stk_we = 1'b1;
		end else if (state_q == S_SCAN && cand_nz && out_free) begin
			stk_we    = 1'b1;
			stk_waddr = depth_q[VI_W-1:0];
			stk_wdata = ffs_idx;
		end
		stk_raddr = depth_m2[VI_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			adj_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= adj_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[mem_waddr] <= 1'b1;
			end
			rd_vld_q <= row_vld_q[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= MODE_INSERT;
			vc_q          <= VC_RESET;
			edges_q       <= '0;
			visited_q     <= '0;
			depth_q       <= '0;
			a_q           <= '0;
			b_q           <= '0;
			top_q         <= '0;
			pend_q        <= '0;
			resp_status_q <= STATUS_OK;
			res_valid_q   <= 1'b0;
			res_vertex_q  <= '0;
			res_status_q  <= STATUS_OK;
			res_count_q   <= '0;
			res_last_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vc_q <= vertex_count;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						a_q    <= a_in;
						b_q    <= VI_W'(vertex_b);
						mode_q <= mode_t'(mode);
						unique case (mode_t'(mode))
							MODE_INSERT, MODE_REMOVE: begin
								if (a_in_ok && b_in_ok) begin
									state_q <= S_EUPD;
								end else begin
									resp_status_q <= STATUS_BAD_VERTEX;
									state_q       <= S_RESP;
								end
							end
							MODE_SEARCH: begin
								if (a_in_ok) begin
									visited_q <= a_in_bit;
									depth_q   <= DEPTH_W'(1);
									top_q     <= a_in;
									pend_q    <= a_in;
									state_q   <= S_SCAN;
								end else begin
									visited_q     <= '0;
									depth_q       <= '0;
									resp_status_q <= STATUS_BAD_VERTEX;
									state_q       <= S_RESP;
								end
							end
							MODE_RSVD: begin
								resp_status_q <= STATUS_OK;
								state_q       <= S_RESP;
							end
						endcase
					end
				end
				S_EUPD: begin
					resp_status_q <= STATUS_OK;
					state_q       <= do_change ? S_EWR_B : S_RESP;
				end
				S_EWR_B: begin
					if (mode_q == MODE_INSERT) begin
						edges_q <= edges_q + COUNT_W'(1);
					end else begin
						edges_q <= edges_q - COUNT_W'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						res_vertex_q <= '0;
						res_status_q <= resp_status_q;
						res_count_q  <= edges_q;
						res_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (cand_nz) begin
						// The held visit is emitted once the next one is known.
						if (out_free) begin
							res_vertex_q <= VID_W'(pend_q);
							res_status_q <= STATUS_OK;
							res_count_q  <= edges_q;
							res_last_q   <= 1'b0;
							pend_q       <= ffs_idx;
							top_q        <= ffs_idx;
							visited_q    <= visited_q | iso;
							depth_q      <= depth_q + DEPTH_W'(1);
						end
					end else if (depth_q == DEPTH_W'(1)) begin
						// Walk is over: the held visit is the final result.
						if (out_free) begin
							res_vertex_q <= VID_W'(pend_q);
							res_status_q <= STATUS_OK;
							res_count_q  <= edges_q;
							res_last_q   <= 1'b1;
							depth_q      <= '0;
							state_q      <= S_IDLE;
						end
					end else begin
						depth_q <= depth_q - DEPTH_W'(1);
						state_q <= S_POP;
					end
				end
				S_POP: begin
					top_q   <= stk_rd_q;
					state_q <= S_SCAN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for graph_matrix_dfs_engine_top: edge insert/remove and depth-first search.
// Depends on gmdfs_pkg for field widths, operation codes and status codes; drives the block directly.

module testbench;
	import gmdfs_pkg::*;

	// One result as it leaves the block. The field order matches the port order.
	typedef struct packed {
		logic [VID_W-1:0]   vertex;
		logic               status;
		logic [COUNT_W-1:0] edges;
		logic               last;
	} result_t;

	// One row of the directed plan. A row can first change the vertex count,
	// and it can carry a hand-written answer instead of the predicted one.
	typedef struct packed {
		logic              write_cfg;
		logic [VC_W-1:0]   cfg_value;
		mode_t             op;
		logic [VID_W-1:0]  va;
		logic [VID_W-1:0]  vb;
		logic              typed;
		result_t           answer;
	} plan_row_t;

	localparam int      PLAN_ROWS    = 25;
	localparam int      HOLD_CYCLES  = 300;
	localparam int      SETTLE       = 16;
	localparam result_t UNTYPED      = '0;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [VC_W-1:0]    vertex_count;
	logic               req_valid;
	logic               req_stall;
	logic [MODE_W-1:0]  mode;
	logic [VID_W-1:0]   vertex_a;
	logic [VID_W-1:0]   vertex_b;
	logic               res_valid;
	logic               res_stall;
	logic [VID_W-1:0]   visited_vertex;
	logic               status;
	logic [COUNT_W-1:0] edge_count;
	logic               last;

	graph_matrix_dfs_engine_top #(
		.MAX_VERTICES(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.vertex_count(vertex_count),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.visited_vertex(visited_vertex),
		.status(status),
		.edge_count(edge_count),
		.last(last)
	);

	// Shadow copy of the graph held by the block, kept in step with every
	// accepted request and every vertex count write.
	logic [31:0]        graph_rows [32];
	logic [COUNT_W-1:0] edge_total;
	logic [VC_W-1:0]    graph_vertex_count;

	// Results of the request just accepted, then the queue of results that
	// the block still owes, oldest first.
	result_t request_results [$];
	result_t awaited_results [$];

	int  mismatch_total;
	int  sender_idle_pct;
	int  receiver_stall_pct;
	bit  hold_request;

	// Directed plan. The first rows run on the reset graph with all 32
	// vertices in use, so their answers are obvious: an empty search, the
	// first insert, then a duplicate insert, a self loop, a remove of an
	// absent edge and the unused operation, none of which touch the count.
	// After a small graph is built, the count is lowered to 8 to hit
	// invalid endpoints, an invalid start, an invalid vertex_b that a search
	// ignores, and edges beyond the count that a search must not follow.
	// A count of zero makes every vertex invalid, 63 behaves as 32, and a
	// count of one leaves vertex 0 alone with all its neighbors masked.
	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{1'b0, 6'd0,  MODE_SEARCH, 5'd0,  5'd31, 1'b1, '{5'd0, STATUS_OK, 9'd0, 1'b1}},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd0,  5'd31, 1'b1, '{5'd0, STATUS_OK, 9'd1, 1'b1}},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd31, 5'd0,  1'b1, '{5'd0, STATUS_OK, 9'd1, 1'b1}},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd17, 5'd17, 1'b1, '{5'd0, STATUS_OK, 9'd1, 1'b1}},
		'{1'b0, 6'd0,  MODE_REMOVE, 5'd3,  5'd4,  1'b1, '{5'd0, STATUS_OK, 9'd1, 1'b1}},
		'{1'b0, 6'd0,  MODE_RSVD,   5'd31, 5'd31, 1'b1, '{5'd0, STATUS_OK, 9'd1, 1'b1}},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd0,  5'd1,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd1,  5'd2,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd2,  5'd9,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd0,  5'd7,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd7,  5'd3,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd9,  5'd30, 1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_SEARCH, 5'd0,  5'd5,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_SEARCH, 5'd31, 5'd0,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_REMOVE, 5'd1,  5'd0,  1'b0, UNTYPED},
		'{1'b1, 6'd8,  MODE_SEARCH, 5'd0,  5'd0,  1'b0, UNTYPED},
		'{1'b0, 6'd0,  MODE_INSERT, 5'd8,  5'd2,  1'b1,
			'{5'd0, STATUS_BAD_VERTEX, 9'd6, 1'b1}},
		'{1'b0, 6'd0,  MODE_REMOVE, 5'd2,  5'd8,  1'b1,
			'{5'd0, STATUS_BAD_VERTEX, 9'd6, 1'b1}},
		'{1'b0, 6'd0,  MODE_SEARCH, 5'd8,  5'd0,  1'b1,
			'{5'd0, STATUS_BAD_VERTEX, 9'd6, 1'b1}},
		'{1'b0, 6'd0,  MODE_SEARCH, 5'd7,  5'd31, 1'b0, UNTYPED},
		'{1'b1, 6'd0,  MODE_INSERT, 5'd0,  5'd0,  1'b1,
			'{5'd0, STATUS_BAD_VERTEX, 9'd6, 1'b1}},
		'{1'b0, 6'd0,  MODE_SEARCH, 5'd0,  5'd0,  1'b1,
			'{5'd0, STATUS_BAD_VERTEX, 9'd6, 1'b1}},
		'{1'b1, 6'd63, MODE_SEARCH, 5'd9,  5'd0,  1'b0, UNTYPED},
		'{1'b1, 6'd1,  MODE_SEARCH, 5'd0,  5'd0,  1'b1, '{5'd0, STATUS_OK, 9'd6, 1'b1}},
		'{1'b0, 6'd0,  MODE_REMOVE, 5'd0,  5'd1,  1'b1,
			'{5'd0, STATUS_BAD_VERTEX, 9'd6, 1'b1}}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Works out the results of one request on the shadow graph and updates
	// the graph. A search result is held back one step so that the final
	// one can be marked as last once the walk has run dry.
	task automatic compute_request_results(input mode_t op, input logic [VID_W-1:0] va,
			input logic [VID_W-1:0] vb);
		int          n;
		int          top;
		int          u;
		int          walk [$];
		logic [31:0] allowed;
		logic [31:0] visited;
		logic [31:0] cand;
		result_t     held;
		request_results.delete();
		n = (graph_vertex_count > 6'd32) ? 32 : int'(graph_vertex_count);
		allowed = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
		held = '0;
		held.last = 1'b1;
		case (op)
			MODE_INSERT, MODE_REMOVE: begin
				if (va >= n || vb >= n) begin
					held.status = STATUS_BAD_VERTEX;
				end else if (op == MODE_INSERT) begin
					if (va != vb && !graph_rows[va][vb]) begin
						graph_rows[va][vb] = 1'b1;
						graph_rows[vb][va] = 1'b1;
						edge_total = edge_total + 1'b1;
					end
				end else if (graph_rows[va][vb]) begin
					graph_rows[va][vb] = 1'b0;
					graph_rows[vb][va] = 1'b0;
					edge_total = edge_total - 1'b1;
				end
				held.edges = edge_total;
				request_results.push_back(held);
			end
			MODE_SEARCH: begin
				held.edges = edge_total;
				if (va >= n) begin
					held.status = STATUS_BAD_VERTEX;
				end else begin
					visited = '0;
					visited[va] = 1'b1;
					walk.push_back(int'(va));
					held.vertex = va;
					held.last = 1'b0;
					while (walk.size() > 0) begin
						top = walk[walk.size() - 1];
						cand = graph_rows[top] & ~visited & allowed;
						if (cand == '0) begin
							void'(walk.pop_back());
						end else begin
							u = 0;
							while (!cand[u])
								u++;
							visited[u] = 1'b1;
							walk.push_back(u);
							request_results.push_back(held);
							held.vertex = u[VID_W-1:0];
						end
					end
					held.last = 1'b1;
				end
				request_results.push_back(held);
			end
			default: begin
				held.edges = edge_total;
				request_results.push_back(held);
			end
		endcase
	endtask

	// Offers one request, waits for the block to take it, then books what
	// the block now owes. Idle cycles before the request follow the sender
	// percentage of the current phase.
	task automatic send_request(input mode_t op, input logic [VID_W-1:0] va,
			input logic [VID_W-1:0] vb, input logic typed, input result_t answer);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		mode = op;
		vertex_a = va;
		vertex_b = vb;
		do
			@(posedge clk);
		while (req_stall);
		compute_request_results(op, va, vb);
		if (typed)
			awaited_results.push_back(answer);
		else
			foreach (request_results[i])
				awaited_results.push_back(request_results[i]);
	endtask

	// Lowers the request line and waits until every owed result is back,
	// then lets the block settle.
	task automatic drain_block;
		@(negedge clk);
		req_valid = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the vertex count. Called only once the block is drained.
	task automatic write_vertex_count(input logic [VC_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		vertex_count = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		graph_vertex_count = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly in-range vertices, so that edges pile up and searches go deep;
	// now and then any id at all, which is invalid under a lowered count.
	function automatic logic [VID_W-1:0] pick_vertex(input int n);
		if (n <= 0 || $urandom_range(9) == 0)
			return VID_W'($urandom_range(31));
		return VID_W'($urandom_range(n - 1));
	endfunction

	task automatic send_random_request;
		int    n;
		int    pick;
		mode_t op;
		n = (graph_vertex_count > 6'd32) ? 32 : int'(graph_vertex_count);
		pick = $urandom_range(99);
		if (pick < 45)
			op = MODE_INSERT;
		else if (pick < 65)
			op = MODE_REMOVE;
		else if (pick < 92)
			op = MODE_SEARCH;
		else
			op = MODE_RSVD;
		send_request(op, pick_vertex(n), pick_vertex(n), 1'b0, UNTYPED);
	endtask

	// Result side: stalls at random in the current phase's proportion. When
	// asked, it holds off for a long stretch so that the output register
	// fills and the block stops taking requests.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				res_stall = 1'b0;
			end else begin
				res_stall = ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Every result taken by the testbench is checked against the oldest
	// one still owed.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result with nothing owed: vertex %0d status %0d edges %0d last %0d",
					visited_vertex, status, edge_count, last);
				mismatch_total++;
			end else begin
				want = awaited_results.pop_front();
				if (visited_vertex !== want.vertex) begin
					$error("visited_vertex: expected %0d, got %0d", want.vertex, visited_vertex);
					mismatch_total++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_total++;
				end
				if (edge_count !== want.edges) begin
					$error("edge_count: expected %0d, got %0d", want.edges, edge_count);
					mismatch_total++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatch_total++;
				end
			end
		end
	end

	// Sequence: reset, the directed plan, then four random phases with
	// different idling and vertex counts. The first random phase has no
	// idling at all, and it opens with the long hold-off on the result side.
	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		vertex_count = VC_RESET;
		req_valid = 1'b0;
		mode = MODE_INSERT;
		vertex_a = '0;
		vertex_b = '0;
		hold_request = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatch_total = 0;
		edge_total = '0;
		graph_vertex_count = VC_RESET;
		foreach (graph_rows[i])
			graph_rows[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].write_cfg) begin
				drain_block();
				write_vertex_count(directed_plan[i].cfg_value);
			end
			send_request(directed_plan[i].op, directed_plan[i].va, directed_plan[i].vb,
				directed_plan[i].typed, directed_plan[i].answer);
		end

		for (phase = 0; phase < 4; phase++) begin
			drain_block();
			case (phase)
				0: begin
					write_vertex_count(6'd32);
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					hold_request = 1'b1;
				end
				1: begin
					write_vertex_count(6'd12);
					sender_idle_pct = 76;
					receiver_stall_pct = 0;
				end
				2: begin
					write_vertex_count(6'd63);
					sender_idle_pct = 0;
					receiver_stall_pct = 76;
				end
				default: begin
					write_vertex_count(VC_W'($urandom_range(63, 1)));
					sender_idle_pct = 25;
					receiver_stall_pct = 25;
				end
			endcase
			repeat (85) send_random_request();
		end

		drain_block();
		if (mismatch_total == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Hard limit, far above the slowest correct run.
	initial begin
		#8000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/gmdfs_pkg.sv
rtl/core/graph_matrix_dfs_engine_top.sv
tb/sv/testbench.sv
